// ----- rtl/core/bms_pkg.sv -----
`default_nettype none
package bms_pkg;

  localparam int MAX_WIDTH = 64;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WID_W     = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W     = 10;
  localparam int THR_W     = 4;
  localparam int CNT_W     = 4;
  localparam int IDX_W     = 2;
  localparam int DATA_W    = 10;
  localparam int NUM_SLOTS = 4;

  localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(50);
  localparam logic [ROW_W-1:0] HEIGHT_RESET = ROW_W'(50);
  localparam logic [THR_W-1:0] THR_RESET    = THR_W'(4);
  localparam logic [WID_W-1:0] WIDTH_MIN    = WID_W'(3);
  localparam logic [WID_W-1:0] WIDTH_MAX    = WID_W'(MAX_WIDTH);
  localparam logic [ROW_W-1:0] HEIGHT_MIN   = ROW_W'(3);

  typedef enum logic [IDX_W-1:0] {
    REG_MAP_WIDTH      = 2'd0,
    REG_MAP_HEIGHT     = 2'd1,
    REG_WALL_THRESHOLD = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [WID_W-1:0] width;
    logic [ROW_W-1:0] height;
    logic [THR_W-1:0] thr;
  } cfg_t;

  typedef struct packed {
    logic             wall;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             row_ge1;
    logic             row_eq1;
    logic             col_ge1;
    logic             col_eq1;
    logic             last_col;
    logic             last_row;
  } stage_t;

  typedef struct packed {
    logic             rd_en;
    logic [COL_W-1:0] rd_addr;
    logic             wr_en;
    logic [COL_W-1:0] wr_addr;
    logic [1:0]       wr_data;
  } mem_req_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             wall;
    logic             last;
  } result_t;

  // window bit dx*3+dy: dx = column c-2..c, dy = row r-2..r
  function automatic logic [CNT_W-1:0] win_count(input logic [8:0] win,
                                                 input logic [2:0] row_mask,
                                                 input logic [2:0] col_mask);
    logic [CNT_W-1:0] sum;
    sum = '0;
    for (int dx = 0; dx < 3; dx++) begin
      for (int dy = 0; dy < 3; dy++) begin
        sum = sum + CNT_W'(win[dx*3+dy] & row_mask[dy] & col_mask[dx]);
      end
    end
    return sum;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/bms_in_if.sv -----
`default_nettype none
interface bms_in_if;
  logic valid;
  logic ready;
  logic cell_is_wall;
  modport source (output valid, output cell_is_wall, input ready);
  modport sink (input valid, input cell_is_wall, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/bms_out_if.sv -----
`default_nettype none
interface bms_out_if;
  logic                      valid;
  logic                      ready;
  logic [bms_pkg::ROW_W-1:0] out_row;
  logic [bms_pkg::COL_W-1:0] out_col;
  logic                      out_wall;
  logic                      frame_last;
  modport source (output valid, output out_row, output out_col, output out_wall,
                  output frame_last, input ready);
  modport sink (input valid, input out_row, input out_col, input out_wall,
                input frame_last, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/bms_cfg_if.sv -----
`default_nettype none
interface bms_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [bms_pkg::IDX_W-1:0]  index;
  logic [bms_pkg::DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/bms_cfg_regs.sv -----
`default_nettype none
module bms_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       wr_en,
  input  wire logic [bms_pkg::IDX_W-1:0]  wr_index,
  input  wire logic [bms_pkg::DATA_W-1:0] wr_data,
  output bms_pkg::cfg_t                   cfg
);

  logic [bms_pkg::WID_W-1:0] width_r;
  logic [bms_pkg::ROW_W-1:0] height_r;
  logic [bms_pkg::THR_W-1:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bms_pkg::WIDTH_RESET;
      height_r <= bms_pkg::HEIGHT_RESET;
      thr_r    <= bms_pkg::THR_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        bms_pkg::REG_MAP_WIDTH:      width_r  <= wr_data[bms_pkg::WID_W-1:0];
        bms_pkg::REG_MAP_HEIGHT:     height_r <= wr_data[bms_pkg::ROW_W-1:0];
        bms_pkg::REG_WALL_THRESHOLD: thr_r    <= wr_data[bms_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp to the supported grid
  always_comb begin
    if (width_r < bms_pkg::WIDTH_MIN) begin
      cfg.width = bms_pkg::WIDTH_MIN;
    end else if (width_r > bms_pkg::WIDTH_MAX) begin
      cfg.width = bms_pkg::WIDTH_MAX;
    end else begin
      cfg.width = width_r;
    end
    cfg.height = (height_r < bms_pkg::HEIGHT_MIN) ? bms_pkg::HEIGHT_MIN : height_r;
    cfg.thr    = thr_r;
  end

endmodule
`default_nettype wire

// ----- rtl/core/bms_line_store.sv -----
`default_nettype none
module bms_line_store (
  input  wire logic          clk,
  input  bms_pkg::mem_req_t  req,
  output logic [1:0]         rd_data
);

  // bit 1: previous row, bit 0: row before it
  logic [1:0] mem [bms_pkg::MAX_WIDTH];
  logic [1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ----- rtl/core/bms_smooth.sv -----
`default_nettype none
module bms_smooth (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  bms_pkg::cfg_t                      cfg,
  input  wire logic                          in_valid,
  input  wire logic                          in_bit,
  output logic                               in_ready,
  input  wire logic                          load_ok,
  output logic                               load,
  output bms_pkg::result_t                   slots [bms_pkg::NUM_SLOTS],
  output logic [bms_pkg::NUM_SLOTS-1:0]      slot_mask,
  output bms_pkg::mem_req_t                  mem_req,
  input  wire logic [1:0]                    mem_rd_data
);

  logic [bms_pkg::ROW_W-1:0] row_r, row_nxt, r_cur;
  logic [bms_pkg::COL_W-1:0] col_r, col_nxt, c_cur;
  logic                      s_valid_r;
  bms_pkg::stage_t           s_r, s_nxt;
  logic [5:0]                win_r, win_nxt;
  logic [5:0]                win_use;
  logic [2:0]                cur;
  logic [8:0]                win9;
  logic                      restart, accept;
  logic [2:0]                rows_all, rows_low, cols_all, cols_right;

  assign load     = s_valid_r && load_ok;
  assign in_ready = !s_valid_r || load;
  assign accept   = in_valid && in_ready;

  always_comb begin
    restart = (row_r >= cfg.height) || ({1'b0, col_r} >= cfg.width);
    r_cur   = restart ? '0 : row_r;
    c_cur   = restart ? '0 : col_r;

    s_nxt.wall     = in_bit;
    s_nxt.row      = r_cur;
    s_nxt.col      = c_cur;
    s_nxt.row_ge1  = (r_cur != '0);
    s_nxt.row_eq1  = (r_cur == bms_pkg::ROW_W'(1));
    s_nxt.col_ge1  = (c_cur != '0);
    s_nxt.col_eq1  = (c_cur == bms_pkg::COL_W'(1));
    s_nxt.last_col = ({1'b0, c_cur} == (cfg.width - bms_pkg::WID_W'(1)));
    s_nxt.last_row = (r_cur == (cfg.height - bms_pkg::ROW_W'(1)));

    if (s_nxt.last_col) begin
      col_nxt = '0;
      row_nxt = s_nxt.last_row ? '0 : r_cur + bms_pkg::ROW_W'(1);
    end else begin
      col_nxt = c_cur + bms_pkg::COL_W'(1);
      row_nxt = r_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r     <= '0;
      col_r     <= '0;
      s_valid_r <= 1'b0;
      win_r     <= '0;
    end else begin
      if (accept) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
      if (accept) begin
        s_valid_r <= 1'b1;
      end else if (load) begin
        s_valid_r <= 1'b0;
      end
      if (load) begin
        win_r <= win_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_r <= s_nxt;
    end
  end

  always_comb begin
    mem_req.rd_en   = accept;
    mem_req.rd_addr = c_cur;
    mem_req.wr_en   = load;
    mem_req.wr_addr = s_r.col;
    mem_req.wr_data = {s_r.wall, mem_rd_data[1]};
  end

  always_comb begin
    cur     = {s_r.wall, mem_rd_data[1], mem_rd_data[0]};
    win_use = s_r.col_ge1 ? win_r : '0;
    win_nxt = {win_use[2:0], cur};
    win9    = {cur, win_use[2:0], win_use[5:3]};

    rows_all   = {2'b11, !s_r.row_eq1};
    rows_low   = 3'b110;
    cols_all   = {2'b11, !s_r.col_eq1};
    cols_right = 3'b110;

    slots[0].row  = s_r.row - bms_pkg::ROW_W'(1);
    slots[0].col  = s_r.col - bms_pkg::COL_W'(1);
    slots[0].wall = !(s_r.row_eq1 && s_r.col_eq1)
                    && (bms_pkg::win_count(win9, rows_all, cols_all) > cfg.thr);
    slots[0].last = 1'b0;

    slots[1].row  = s_r.row - bms_pkg::ROW_W'(1);
    slots[1].col  = s_r.col;
    slots[1].wall = !s_r.row_eq1
                    && (bms_pkg::win_count(win9, rows_all, cols_right) > cfg.thr);
    slots[1].last = 1'b0;

    slots[2].row  = s_r.row;
    slots[2].col  = s_r.col - bms_pkg::COL_W'(1);
    slots[2].wall = !s_r.col_eq1
                    && (bms_pkg::win_count(win9, rows_low, cols_all) > cfg.thr);
    slots[2].last = 1'b0;

    slots[3].row  = s_r.row;
    slots[3].col  = s_r.col;
    slots[3].wall = 1'b0;
    slots[3].last = 1'b1;

    slot_mask[0] = s_r.row_ge1 && s_r.col_ge1;
    slot_mask[1] = s_r.row_ge1 && s_r.last_col;
    slot_mask[2] = s_r.last_row && s_r.col_ge1;
    slot_mask[3] = s_r.last_row && s_r.last_col;
  end

endmodule
`default_nettype wire

// ----- rtl/core/bms_out_buf.sv -----
`default_nettype none
module bms_out_buf (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          load,
  input  bms_pkg::result_t                   load_slots [bms_pkg::NUM_SLOTS],
  input  wire logic [bms_pkg::NUM_SLOTS-1:0] load_mask,
  output logic                               load_ok,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output bms_pkg::result_t                   out_word
);

  bms_pkg::result_t                slots_r [bms_pkg::NUM_SLOTS];
  logic [bms_pkg::NUM_SLOTS-1:0]   mask_r, mask_nxt, pick;
  logic                            single, take;

  assign out_valid = |mask_r;
  assign take      = out_valid && out_ready;
  assign single    = (mask_r & (mask_r - bms_pkg::NUM_SLOTS'(1))) == '0;
  assign load_ok   = !out_valid || (single && out_ready);

  // lowest pending slot goes first
  assign pick = mask_r & (~mask_r + bms_pkg::NUM_SLOTS'(1));

  always_comb begin
    out_word = slots_r[0];
    for (int i = 0; i < bms_pkg::NUM_SLOTS; i++) begin
      if (pick[i]) begin
        out_word = slots_r[i];
      end
    end
  end

  always_comb begin
    mask_nxt = mask_r;
    if (take) begin
      mask_nxt = mask_r & ~pick;
    end
    if (load) begin
      mask_nxt = load_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots_r <= load_slots;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/binary_majority_smoothing.sv -----
// 3x3 majority smoothing of a wall/floor grid streamed in raster order.
// in_ch: one cell per word, row by row, map_width cells a row, map_height rows.
// out_ch: one smoothed cell per word with its row and column; frame_last marks
//   the bottom-right cell. A cell is emitted once its window has arrived, so
//   results trail the input by about one row.
// cfg_ch: register writes (0 map_width, 1 map_height, 2 wall_threshold), always
//   ready; write only while no word is in flight.
// A taken word waits in the smoothing stage until the output buffer can load
//   its results; the buffer then presents them one at a time, lowest slot first.
// Throughput: one input word per cycle while out_ch is ready. Each word yields
//   up to four results and the output port moves one per cycle, so the input
//   pauses at each row end and on the last row, most at its end.
// The two previous rows sit in a 64 x 2-bit line store read when a word is
//   accepted and written when its results load; a column recurs only after
//   three or more words, so no forwarding path is needed.
// Reset: counters restart at row 0, column 0; registers go to 50, 50, 4; the
//   line store is not cleared, and entries not yet written are masked out.
// A stalled receiver holds the results in place and backs up the input.
`default_nettype none
module binary_majority_smoothing (
  input wire logic  clk,
  input wire logic  rst_n,
  bms_in_if.sink    in_ch,
  bms_out_if.source out_ch,
  bms_cfg_if.sink   cfg_ch
);

  bms_pkg::cfg_t                 cfg;
  bms_pkg::mem_req_t             mem_req;
  logic [1:0]                    mem_rd_data;
  logic                          load, load_ok;
  bms_pkg::result_t              slots [bms_pkg::NUM_SLOTS];
  logic [bms_pkg::NUM_SLOTS-1:0] slot_mask;
  bms_pkg::result_t              out_word;

  assign cfg_ch.ready = 1'b1;

  bms_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  bms_line_store u_line_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

  bms_smooth u_smooth (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_valid    (in_ch.valid),
    .in_bit      (in_ch.cell_is_wall),
    .in_ready    (in_ch.ready),
    .load_ok     (load_ok),
    .load        (load),
    .slots       (slots),
    .slot_mask   (slot_mask),
    .mem_req     (mem_req),
    .mem_rd_data (mem_rd_data)
  );

  bms_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .load_slots (slots),
    .load_mask  (slot_mask),
    .load_ok    (load_ok),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_word   (out_word)
  );

  assign out_ch.out_row    = out_word.row;
  assign out_ch.out_col    = out_word.col;
  assign out_ch.out_wall   = out_word.wall;
  assign out_ch.frame_last = out_word.last;

endmodule
`default_nettype wire
